[sv/ttl_token_table_top_defines.svh]
// assertion macros shared by the checker of the token table
// no dependencies
`ifndef TTL_TOKEN_TABLE_TOP_DEFINES_SVH
`define TTL_TOKEN_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TTL_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ttl_token_table: same-cycle check failed");

// next-cycle implication, checked outside reset
`define TTL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ttl_token_table: next-cycle check failed");

`endif

[sv/ttl_pkg.sv]
// types and constants of the token table
// no dependencies
package ttl_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned TIME_W = 31;
  localparam int unsigned EXP_W  = 32;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned MODE_W = 2;

  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [TIME_W-1:0] TTL_RESET = TIME_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_GENERATE = 2'd0,
    MODE_RENEW    = 2'd1,
    MODE_COUNT    = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [EXP_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] live_count;
    logic             status;
  } result_t;

endpackage

[sv/ttl_ram.sv]
// generic single-port synchronous ram with registered read
// no dependencies
module ttl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/ttl_engine.sv]
// scan sequencer of the token table: clears, scans and updates the entry ram
// depends on ttl_pkg
module ttl_engine #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ttl_pkg::MODE_W-1:0]    mode_i,
  input  logic [ttl_pkg::KEY_W-1:0]     token_key_i,
  input  logic [ttl_pkg::TIME_W-1:0]    current_time_i,
  input  logic [ttl_pkg::TIME_W-1:0]    ttl_i,
  output logic                          ram_we_o,
  output logic [$clog2(ENTRIES)-1:0]    ram_addr_o,
  output ttl_pkg::entry_t               ram_wdata_o,
  input  ttl_pkg::entry_t               ram_rdata_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output ttl_pkg::result_t              res_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  ttl_pkg::state_e state_q, state_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [AW-1:0]   eval_idx_q;
  logic            eval_q;

  ttl_pkg::mode_e             mode_q;
  logic [ttl_pkg::KEY_W-1:0]  key_q;
  logic [ttl_pkg::TIME_W-1:0] now_q;

  logic                       hit_q, hit_live_q, free_q, full_q;
  logic [AW-1:0]              hit_idx_q, free_idx_q;
  logic [ttl_pkg::CNT_W-1:0]  count_q;

  logic [ttl_pkg::EXP_W-1:0]  now_ext, expiry;
  logic                       e_match, e_free, e_live;
  logic                       do_write;
  logic [AW-1:0]              write_idx;

  assign now_ext = {1'b0, now_q};
  assign expiry  = now_ext + {1'b0, ttl_i};
  assign e_match = ram_rdata_i.valid && (ram_rdata_i.key == key_q);
  assign e_free  = !ram_rdata_i.valid || (ram_rdata_i.expiry <= now_ext);
  assign e_live  = ram_rdata_i.valid && (ram_rdata_i.expiry > now_ext);

  always_comb begin
    do_write  = 1'b0;
    write_idx = hit_idx_q;
    case (mode_q)
      ttl_pkg::MODE_GENERATE: begin
        do_write  = hit_q || free_q;
        write_idx = hit_q ? hit_idx_q : free_idx_q;
      end
      ttl_pkg::MODE_RENEW: begin
        do_write = hit_q && hit_live_q;
      end
      default: begin
        do_write = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    unique case (state_q)
      ttl_pkg::ST_CLEAR: begin
        addr_d = addr_q + AW'(1);
        if (addr_q == LAST) begin
          state_d = ttl_pkg::ST_IDLE;
          addr_d  = '0;
        end
      end
      ttl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ttl_pkg::ST_SCAN;
          addr_d  = '0;
        end
      end
      ttl_pkg::ST_SCAN: begin
        addr_d = addr_q + AW'(1);
        if (addr_q == LAST) begin
          state_d = ttl_pkg::ST_DRAIN;
          addr_d  = '0;
        end
      end
      ttl_pkg::ST_DRAIN: state_d = ttl_pkg::ST_WRITE;
      ttl_pkg::ST_WRITE: state_d = ttl_pkg::ST_DONE;
      ttl_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = ttl_pkg::ST_IDLE;
        end
      end
      default: state_d = ttl_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = addr_q;
    ram_wdata_o = '0;
    unique case (state_q)
      ttl_pkg::ST_CLEAR: ram_we_o = 1'b1;
      ttl_pkg::ST_IDLE:  in_ready_o = 1'b1;
      ttl_pkg::ST_WRITE: begin
        ram_we_o           = do_write;
        ram_addr_o         = write_idx;
        ram_wdata_o.valid  = 1'b1;
        ram_wdata_o.key    = key_q;
        ram_wdata_o.expiry = expiry;
      end
      ttl_pkg::ST_DONE:  res_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign res_o.live_count = (mode_q == ttl_pkg::MODE_COUNT) ? count_q : '0;
  assign res_o.status     = full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttl_pkg::ST_CLEAR;
      addr_q  <= '0;
      eval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      eval_q  <= (state_q == ttl_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    eval_idx_q <= addr_q;
    if (in_valid_i && in_ready_o) begin
      mode_q     <= ttl_pkg::mode_e'(mode_i);
      key_q      <= token_key_i;
      now_q      <= current_time_i;
      hit_q      <= 1'b0;
      hit_live_q <= 1'b0;
      hit_idx_q  <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      count_q    <= '0;
      full_q     <= 1'b0;
    end else begin
      if (eval_q) begin
        if (e_match && !hit_q) begin
          hit_q      <= 1'b1;
          hit_idx_q  <= eval_idx_q;
          hit_live_q <= e_live;
        end
        if (e_free && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= eval_idx_q;
        end
        if (e_live && (count_q != ttl_pkg::CNT_MAX)) begin
          count_q <= count_q + ttl_pkg::CNT_W'(1);
        end
      end
      if (state_q == ttl_pkg::ST_WRITE) begin
        full_q <= (mode_q == ttl_pkg::MODE_GENERATE) && !hit_q && !free_q;
      end
    end
  end

endmodule

[sv/ttl_token_table_top.sv]
// A table of ENTRIES 64-bit keys with expiry times, kept in one single-port
// ram of ENTRIES words. Generate (mode 0) sets a key's expiry to
// current_time + time_to_live, inserting it in the lowest free or expired
// slot, and reports status 1 when no slot is left. Renew (mode 1) does the
// same for a present, unexpired key only. Count (mode 2) returns the number
// of entries that expire after current_time, saturating at 127. After reset
// the block clears every ram word before it takes a beat. Each operation
// reads every entry once through the single ram port and then writes at
// most one back, and takes no new beat until it is done; the result sits
// in an output register, so the next beat is taken while it waits.
// Depends on ttl_pkg, ttl_ram and ttl_engine.
module ttl_token_table_top #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ttl_pkg::TIME_W-1:0] time_to_live_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ttl_pkg::MODE_W-1:0] mode_i,
  input  logic [ttl_pkg::KEY_W-1:0]  token_key_i,
  input  logic [ttl_pkg::TIME_W-1:0] current_time_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ttl_pkg::CNT_W-1:0]  live_count_o,
  output logic                       status_o
);

  localparam int unsigned AW = $clog2(ENTRIES);

  logic [ttl_pkg::TIME_W-1:0] ttl_q;
  logic                       ram_we;
  logic [AW-1:0]              ram_addr;
  ttl_pkg::entry_t            ram_wdata, ram_rdata;
  logic                       res_valid, res_ready;
  ttl_pkg::result_t           res;
  logic                       out_valid_q;
  ttl_pkg::result_t           out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= ttl_pkg::TTL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ttl_q <= time_to_live_i;
    end
  end

  ttl_ram #(
    .WIDTH ($bits(ttl_pkg::entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  ttl_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .token_key_i    (token_key_i),
    .current_time_i (current_time_i),
    .ttl_i          (ttl_q),
    .ram_we_o       (ram_we),
    .ram_addr_o     (ram_addr),
    .ram_wdata_o    (ram_wdata),
    .ram_rdata_i    (ram_rdata),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign live_count_o = out_q.live_count;
  assign status_o     = out_q.status;

endmodule

[sv/ttl_token_table_chk.sv]
// port-level checker of the token table and its bind to the top level
// depends on ttl_token_table_top_defines.svh and ttl_token_table_top
`include "ttl_token_table_top_defines.svh"

module ttl_token_table_chk #(
  parameter int unsigned ENTRIES = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [6:0]  live_count_o,
  input logic        status_o
);

  `TTL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(live_count_o) && $stable(status_o))
  `TTL_ASSERT_NOW(a_full_no_count, clk_i, rst_ni, out_valid_o && status_o, live_count_o == 7'd0)
  `TTL_ASSERT_NOW(a_count_bound, clk_i, rst_ni, out_valid_o, 32'(live_count_o) <= 32'(ENTRIES))
  `TTL_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind ttl_token_table_top ttl_token_table_chk #(.ENTRIES(ENTRIES)) u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .live_count_o (live_count_o),
  .status_o     (status_o)
);

[tb/tb_top.sv]
// self-checking testbench of ttl_token_table_top: directed and random generate, renew and count
// beats with random idling on both sides, checked against a table predictor kept in the bench
// depends on ttl_pkg and ttl_token_table_top
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned TARGET_ITEMS = 1350;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int unsigned TAIL_CYCLES = ENTRIES + 8;
  localparam logic [ttl_pkg::MODE_W-1:0] MODE_NONE = 2'd3;
  localparam logic [ttl_pkg::TIME_W-1:0] TIME_MAX = {ttl_pkg::TIME_W{1'b1}};

  typedef struct packed {
    logic [ttl_pkg::MODE_W-1:0] mode;
    logic [ttl_pkg::KEY_W-1:0]  key;
    logic [ttl_pkg::TIME_W-1:0] now;
  } token_op_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ttl_pkg::TIME_W-1:0] time_to_live_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ttl_pkg::MODE_W-1:0] mode_i = '0;
  logic [ttl_pkg::KEY_W-1:0] token_key_i = '0;
  logic [ttl_pkg::TIME_W-1:0] current_time_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ttl_pkg::CNT_W-1:0] live_count_o;
  logic status_o;

  // predictor state
  logic [ttl_pkg::KEY_W-1:0] slot_key [ENTRIES];
  logic [ttl_pkg::EXP_W-1:0] slot_expiry [ENTRIES];
  logic slot_used [ENTRIES] = '{default: 1'b0};
  logic [ttl_pkg::TIME_W-1:0] live_ttl = ttl_pkg::TTL_RESET;

  token_op_t op_queue [$];
  ttl_pkg::result_t reply_q [$];
  token_op_t cur_op;
  ttl_pkg::result_t want;
  int gap_left = 0;
  int stall_left = 0;
  bit steady = 1'b0;
  int fails = 0;
  longint cycle_count = 0;

  ttl_token_table_top #(.ENTRIES(ENTRIES)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .time_to_live_i (time_to_live_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .token_key_i    (token_key_i),
    .current_time_i (current_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .live_count_o   (live_count_o),
    .status_o       (status_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int find_key(input logic [ttl_pkg::KEY_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic ttl_pkg::result_t apply_token_op(input token_op_t op);
    int hit;
    logic [ttl_pkg::EXP_W-1:0] now32;
    logic [ttl_pkg::EXP_W-1:0] new_expiry;
    ttl_pkg::result_t r;
    now32 = ttl_pkg::EXP_W'(op.now);
    new_expiry = now32 + ttl_pkg::EXP_W'(live_ttl);
    r = '0;
    case (op.mode)
      ttl_pkg::MODE_GENERATE: begin
        hit = find_key(op.key);
        if (hit < 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_used[i] || slot_expiry[i] <= now32) begin
              hit = i;
              break;
            end
          end
          if (hit >= 0) begin
            slot_key[hit] = op.key;
            slot_used[hit] = 1'b1;
          end
        end
        if (hit >= 0) slot_expiry[hit] = new_expiry;
        else r.status = 1'b1;
      end
      ttl_pkg::MODE_RENEW: begin
        hit = find_key(op.key);
        if (hit >= 0 && slot_expiry[hit] > now32) slot_expiry[hit] = new_expiry;
      end
      ttl_pkg::MODE_COUNT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && slot_expiry[i] > now32 && r.live_count < ttl_pkg::CNT_MAX) begin
            r.live_count++;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    fails++;
  endtask

  task automatic queue_op(input logic [ttl_pkg::MODE_W-1:0] m,
                          input logic [ttl_pkg::KEY_W-1:0] k,
                          input logic [ttl_pkg::TIME_W-1:0] t);
    token_op_t op;
    op.mode = m;
    op.key = k;
    op.now = t;
    op_queue.push_back(op);
  endtask

  task automatic write_ttl(input logic [ttl_pkg::TIME_W-1:0] ttl);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    time_to_live_i <= ttl;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    live_ttl = ttl;
  endtask

  task automatic await_drain();
    while (op_queue.size() != 0 || in_valid_i || reply_q.size() != 0) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) reply_q.push_back(apply_token_op(cur_op));
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (op_queue.size() != 0) begin
          if (!steady && $urandom_range(0, 99) < 32) begin
            in_valid_i <= 1'b0;
            gap_left = ($urandom_range(0, 39) == 0) ? $urandom_range(2, 90) : 0;
          end else begin
            cur_op = op_queue.pop_front();
            mode_i <= cur_op.mode;
            token_key_i <= cur_op.key;
            current_time_i <= cur_op.now;
            in_valid_i <= 1'b1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result beat with no pending expectation");
        end else begin
          want = reply_q.pop_front();
          if (live_count_o !== want.live_count) begin
            report_mismatch($sformatf("live_count %0d, want %0d", live_count_o,
                                      want.live_count));
          end
          if (status_o !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 32) begin
        out_ready_i <= 1'b0;
        stall_left = ($urandom_range(0, 39) == 0) ? $urandom_range(2, 150) : 0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int total;
    int phase;
    int n;
    int pool_n;
    int r;
    logic [ttl_pkg::KEY_W-1:0] pool [$];
    logic [ttl_pkg::KEY_W-1:0] k;
    logic [ttl_pkg::TIME_W-1:0] clock_now;
    logic [ttl_pkg::TIME_W-1:0] ttl_pick;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: boundaries of expiry, renew rules, idle mode
    write_ttl(ttl_pkg::TIME_W'(100));
    queue_op(ttl_pkg::MODE_COUNT, {$urandom, $urandom}, '0);
    queue_op(ttl_pkg::MODE_GENERATE, '0, '0);
    queue_op(ttl_pkg::MODE_GENERATE, '1, TIME_MAX);
    queue_op(ttl_pkg::MODE_COUNT, '0, ttl_pkg::TIME_W'(50));
    queue_op(ttl_pkg::MODE_RENEW, '0, ttl_pkg::TIME_W'(99));
    queue_op(ttl_pkg::MODE_RENEW, 64'h0123_4567_89ab_cdef, ttl_pkg::TIME_W'(99));
    queue_op(ttl_pkg::MODE_GENERATE, '0, ttl_pkg::TIME_W'(500));
    queue_op(ttl_pkg::MODE_RENEW, '1, TIME_MAX);
    queue_op(MODE_NONE, {$urandom, $urandom}, ttl_pkg::TIME_W'($urandom));
    queue_op(ttl_pkg::MODE_GENERATE, 64'h5, ttl_pkg::TIME_W'(1000));
    queue_op(ttl_pkg::MODE_RENEW, 64'h5, ttl_pkg::TIME_W'(1100));
    queue_op(ttl_pkg::MODE_COUNT, '0, ttl_pkg::TIME_W'(1099));
    queue_op(ttl_pkg::MODE_COUNT, '1, ttl_pkg::TIME_W'(1100));
    total = op_queue.size();
    await_drain();

    // zero lifetime
    write_ttl('0);
    queue_op(ttl_pkg::MODE_GENERATE, 64'h7, ttl_pkg::TIME_W'(10));
    queue_op(ttl_pkg::MODE_COUNT, '0, ttl_pkg::TIME_W'(9));
    queue_op(ttl_pkg::MODE_COUNT, '0, ttl_pkg::TIME_W'(10));
    queue_op(ttl_pkg::MODE_RENEW, 64'h7, ttl_pkg::TIME_W'(9));
    total += op_queue.size();
    await_drain();

    // largest lifetime at the largest time stamp
    write_ttl(TIME_MAX);
    queue_op(ttl_pkg::MODE_GENERATE, 64'haaaa_aaaa_aaaa_aaaa, TIME_MAX);
    queue_op(ttl_pkg::MODE_COUNT, '0, TIME_MAX);
    queue_op(ttl_pkg::MODE_GENERATE, 64'h5555_5555_5555_5555, '0);
    queue_op(ttl_pkg::MODE_COUNT, '1, '0);
    total += op_queue.size();
    await_drain();

    // random phases, each with its own lifetime and key pool
    phase = 0;
    while (total < TARGET_ITEMS) begin
      case (phase % 5)
        0: ttl_pick = TIME_MAX;
        1: ttl_pick = ttl_pkg::TIME_W'(1);
        2: ttl_pick = ttl_pkg::TIME_W'($urandom_range(8, 400));
        3: ttl_pick = ttl_pkg::TIME_W'($urandom);
        default: ttl_pick = (phase % 10 == 4) ? '0 : ttl_pkg::TIME_W'($urandom_range(1, 40));
      endcase
      write_ttl(ttl_pick);
      steady = (phase == 1);

      case ($urandom_range(0, 2))
        0: pool_n = 6;
        1: pool_n = 48;
        default: pool_n = 90;
      endcase
      if (phase == 0) pool_n = 90;
      pool.delete();
      for (int i = 0; i < pool_n; i++) pool.push_back({$urandom, $urandom});

      case ($urandom_range(0, 2))
        0: clock_now = ttl_pkg::TIME_W'($urandom_range(0, 50));
        1: clock_now = TIME_MAX - ttl_pkg::TIME_W'($urandom_range(0, 3000));
        default: clock_now = ttl_pkg::TIME_W'($urandom);
      endcase

      n = $urandom_range(60, 140);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 70) clock_now += ttl_pkg::TIME_W'($urandom_range(0, 4));
        else if ($urandom_range(0, 9) != 0) begin
          clock_now += ttl_pkg::TIME_W'($urandom_range(0, 60));
        end
        else clock_now = ttl_pkg::TIME_W'($urandom);
        k = ($urandom_range(0, 9) != 0) ? pool[$urandom_range(0, pool_n - 1)]
                                        : {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 45) queue_op(ttl_pkg::MODE_GENERATE, k, clock_now);
        else if (r < 70) queue_op(ttl_pkg::MODE_RENEW, k, clock_now);
        else if (r < 93) queue_op(ttl_pkg::MODE_COUNT, k, clock_now);
        else if (r < 97) queue_op(MODE_NONE, k, clock_now);
        else begin
          queue_op(ttl_pkg::MODE_W'($urandom), {$urandom, $urandom},
                   ttl_pkg::TIME_W'($urandom));
        end
      end
      total += n;
      await_drain();
      steady = 1'b0;
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[ttl_token_table_top.f]
+incdir+sv
sv/ttl_pkg.sv
sv/ttl_ram.sv
sv/ttl_engine.sv
sv/ttl_token_table_top.sv
sv/ttl_token_table_chk.sv
tb/tb_top.sv
